### hdl/nps_pkg.sv
package nps_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam logic [1:0] CFG_ANGLE_WEIGHT = 2'd0;
    localparam logic [1:0] CFG_EXCL_RADIUS  = 2'd1;
    localparam logic [1:0] CFG_SEARCH_LIMIT = 2'd2;

    localparam logic [7:0]  RST_ANGLE_WEIGHT = 8'd100;
    localparam logic [31:0] RST_EXCL_RADIUS  = 32'd4194304;
    localparam logic [47:0] RST_SEARCH_LIMIT = 48'd6553600000000;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SELECTED  = 3'd3;
    localparam logic [2:0] ST_FALLBACK  = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic               opcode;
        logic signed [19:0] pose_x;
        logic signed [19:0] pose_y;
        logic signed [15:0] pose_heading;
        logic [31:0]        pose_time;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         entry_index;
        logic signed [19:0] out_x;
        logic signed [19:0] out_y;
        logic signed [15:0] out_heading;
        logic [31:0]        out_time;
        logic [47:0]        best_distance_sq;
    } t_out_beat;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [15:0] h;
        logic [31:0]        t;
    } t_pose;

    typedef struct packed {
        logic        opcode;
        t_pose       probe;
        logic [7:0]  weight;
        logic [31:0] excl;
    } t_cell_ctl;

endpackage

### hdl/nearest_pose_selector_unit.sv
// Insert and query both send a token from the start register through the chain of
// cells to the result register; three register stages per cell.
// One item at a time: a new item is taken only after the last result is accepted.
// Reset (synchronous, active low) empties the table and loads register defaults.
module nearest_pose_selector_unit #(
    parameter int TABLE_DEPTH = nps_pkg::TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  nps_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output nps_pkg::t_out_beat  o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    logic [7:0]  r_weight;
    logic [31:0] r_excl;
    logic [47:0] r_limit;
    logic [CW-1:0] r_count;
    logic        r_busy;
    nps_pkg::t_cell_ctl r_ctl;
    logic        r_start;

    logic signed [19:0] r_first_x, r_first_y;
    logic signed [15:0] r_first_h;
    logic [31:0]        r_first_t;

    logic               full;
    logic               store;
    nps_pkg::t_out_beat n_data;

    logic           tv [TABLE_DEPTH+1];
    logic           tf [TABLE_DEPTH+1];
    logic [47:0]    tb [TABLE_DEPTH+1];
    nps_pkg::t_pose tp [TABLE_DEPTH+1];
    logic [IW-1:0]  ts [TABLE_DEPTH+1];

    assign tv[0] = r_start;
    assign tf[0] = 1'b0;
    assign tb[0] = r_limit;
    assign tp[0] = '0;
    assign ts[0] = '0;

    assign o_ready = !r_busy;

    assign full  = (r_count == CW'(TABLE_DEPTH));
    assign store = tv[TABLE_DEPTH] && !r_ctl.opcode && !tf[TABLE_DEPTH] && !full;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic ld;
            assign ld = store && (r_count == CW'(g));
            nps_cell #(
                .IDX_W(IW)
            ) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_load(ld), .i_load_pose(r_ctl.probe), .i_ctl(r_ctl),
                .i_tok_valid(tv[g]), .i_tok_found(tf[g]), .i_tok_best(tb[g]),
                .i_tok_pose(tp[g]), .i_tok_sel(ts[g]), .i_my_index(IW'(g)),
                .o_tok_valid(tv[g+1]), .o_tok_found(tf[g+1]), .o_tok_best(tb[g+1]),
                .o_tok_pose(tp[g+1]), .o_tok_sel(ts[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_data = '0;
        if (!r_ctl.opcode) begin
            if (tf[TABLE_DEPTH]) begin
                n_data.status      = nps_pkg::ST_DUPLICATE;
                n_data.entry_index = 6'(ts[TABLE_DEPTH]);
                n_data.out_x       = tp[TABLE_DEPTH].x;
                n_data.out_y       = tp[TABLE_DEPTH].y;
                n_data.out_heading = tp[TABLE_DEPTH].h;
                n_data.out_time    = tp[TABLE_DEPTH].t;
            end else if (full) begin
                n_data.status = nps_pkg::ST_FULL;
            end else begin
                n_data.status      = nps_pkg::ST_INSERTED;
                n_data.entry_index = 6'(r_count);
                n_data.out_x       = r_ctl.probe.x;
                n_data.out_y       = r_ctl.probe.y;
                n_data.out_heading = r_ctl.probe.h;
                n_data.out_time    = r_ctl.probe.t;
            end
        end else if (r_count == '0) begin
            n_data.status = nps_pkg::ST_EMPTY;
        end else if (tf[TABLE_DEPTH]) begin
            n_data.status           = nps_pkg::ST_SELECTED;
            n_data.entry_index      = 6'(ts[TABLE_DEPTH]);
            n_data.out_x            = tp[TABLE_DEPTH].x;
            n_data.out_y            = tp[TABLE_DEPTH].y;
            n_data.out_heading      = tp[TABLE_DEPTH].h;
            n_data.out_time         = tp[TABLE_DEPTH].t;
            n_data.best_distance_sq = tb[TABLE_DEPTH];
        end else begin
            n_data.status           = nps_pkg::ST_FALLBACK;
            n_data.out_x            = r_first_x;
            n_data.out_y            = r_first_y;
            n_data.out_heading      = r_first_h;
            n_data.out_time         = r_first_t;
            n_data.best_distance_sq = r_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= nps_pkg::RST_ANGLE_WEIGHT;
            r_excl   <= nps_pkg::RST_EXCL_RADIUS;
            r_limit  <= nps_pkg::RST_SEARCH_LIMIT;
            r_count  <= '0;
            r_busy   <= 1'b0;
            r_start  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nps_pkg::CFG_ANGLE_WEIGHT: r_weight <= i_cfg_data[7:0];
                    nps_pkg::CFG_EXCL_RADIUS:  r_excl   <= i_cfg_data[31:0];
                    nps_pkg::CFG_SEARCH_LIMIT: r_limit  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_start <= i_valid && !r_busy;
            if (i_valid && !r_busy)
                r_busy <= 1'b1;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
                r_busy  <= 1'b0;
            end
            if (tv[TABLE_DEPTH]) begin
                o_valid <= 1'b1;
                if (store)
                    r_count <= r_count + 1'b1;
            end
        end
        if (i_valid && !r_busy) begin
            r_ctl.opcode <= i_data.opcode;
            r_ctl.probe  <= '{x: i_data.pose_x, y: i_data.pose_y,
                               h: i_data.pose_heading, t: i_data.pose_time};
            r_ctl.weight <= r_weight;
            r_ctl.excl   <= r_excl;
        end
        if (tv[TABLE_DEPTH])
            o_data <= n_data;
        if (store && r_count == '0) begin
            r_first_x <= r_ctl.probe.x;
            r_first_y <= r_ctl.probe.y;
            r_first_h <= r_ctl.probe.h;
            r_first_t <= r_ctl.probe.t;
        end
    end

endmodule

### hdl/nps_cell.sv
module nps_cell #(
    parameter int IDX_W = $clog2(nps_pkg::TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  nps_pkg::t_pose     i_load_pose,
    input  nps_pkg::t_cell_ctl i_ctl,
    input  logic               i_tok_valid,
    input  logic               i_tok_found,
    input  logic [47:0]        i_tok_best,
    input  nps_pkg::t_pose     i_tok_pose,
    input  logic [IDX_W-1:0]   i_tok_sel,
    input  logic [IDX_W-1:0]   i_my_index,
    output logic               o_tok_valid,
    output logic               o_tok_found,
    output logic [47:0]        o_tok_best,
    output nps_pkg::t_pose     o_tok_pose,
    output logic [IDX_W-1:0]   o_tok_sel
);

    nps_pkg::t_pose   r_pose;
    logic             r_used;
    logic             r_v1;
    logic             r_f1;
    logic [47:0]      r_b1;
    nps_pkg::t_pose   r_p1;
    logic [IDX_W-1:0] r_s1;
    logic [40:0]      r_sxy;
    logic [31:0]      r_shh;
    logic             r_v2;
    logic             r_f2;
    logic [47:0]      r_b2;
    nps_pkg::t_pose   r_p2;
    logic [IDX_W-1:0] r_s2;

    logic signed [20:0] dx, dy;
    logic signed [16:0] dh;
    logic [20:0] ax, ay;
    logic [16:0] ah;
    logic [47:0] d;
    logic        hit;

    assign dx = 21'(i_ctl.probe.x) - 21'(r_pose.x);
    assign dy = 21'(i_ctl.probe.y) - 21'(r_pose.y);
    assign dh = 17'(i_ctl.probe.h) - 17'(r_pose.h);
    assign ax = dx[20] ? 21'(-dx) : 21'(dx);
    assign ay = dy[20] ? 21'(-dy) : 21'(dy);
    assign ah = dh[16] ? 17'(-dh) : 17'(dh);
    assign d  = 48'(r_sxy) + 48'((40'(i_ctl.weight) * 40'(r_shh)) >> 8);

    always_comb begin
        hit = 1'b0;
        if (r_used) begin
            if (i_ctl.opcode)
                hit = (d < r_b2) && (d > 48'(i_ctl.excl));
            else
                hit = !r_f2 && (r_pose.t[31:8] == i_ctl.probe.t[31:8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            o_tok_valid <= 1'b0;
        end else begin
            if (i_load)
                r_used <= 1'b1;
            r_v1 <= i_tok_valid;
            r_v2 <= r_v1;
            o_tok_valid <= r_v2;
        end
        if (i_load)
            r_pose <= i_load_pose;
        r_f1 <= i_tok_found;
        r_b1 <= i_tok_best;
        r_p1 <= i_tok_pose;
        r_s1 <= i_tok_sel;
        r_sxy <= 41'(ax * ax) + 41'(ay * ay);
        r_shh <= 32'(ah * ah);
        r_f2 <= r_f1;
        r_b2 <= r_b1;
        r_p2 <= r_p1;
        r_s2 <= r_s1;
        o_tok_found <= hit ? 1'b1 : r_f2;
        o_tok_best  <= (hit && i_ctl.opcode) ? d : r_b2;
        o_tok_pose  <= hit ? r_pose : r_p2;
        o_tok_sel   <= hit ? i_my_index : r_s2;
    end

endmodule

### verif/tb_nearest_pose_selector_unit.sv
`timescale 1ns / 100ps

module tb_nearest_pose_selector_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CFG_NONE = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    nps_pkg::t_in_beat   i_data;
    logic                o_valid;
    logic                i_ready;
    nps_pkg::t_out_beat  o_data;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [47:0]         i_cfg_data;

    nearest_pose_selector_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    nps_pkg::t_pose pose_tab [nps_pkg::TABLE_DEPTH];
    int          pose_cnt;
    logic [7:0]  wgt;
    logic [31:0] excl_sq;
    logic [47:0] limit_sq;

    nps_pkg::t_out_beat expected_beats [$];
    int          err_cnt;
    int          idle_cycles;
    bit          stall_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [47:0] sq_diff(input longint a, input longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return 48'(d * d);
    endfunction

    function automatic nps_pkg::t_out_beat select_pose(input nps_pkg::t_in_beat b);
        nps_pkg::t_out_beat r;
        nps_pkg::t_pose     p;
        logic [47:0] best, d;
        int          sel;
        bit          found;
        r = '0;
        p.x = b.pose_x;
        p.y = b.pose_y;
        p.h = b.pose_heading;
        p.t = b.pose_time;
        if (b.opcode == 1'b0) begin
            for (int i = 0; i < pose_cnt; i++) begin
                if (pose_tab[i].t[31:8] == p.t[31:8]) begin
                    r.status = nps_pkg::ST_DUPLICATE;
                    r.entry_index = 6'(i);
                    r.out_x = pose_tab[i].x;
                    r.out_y = pose_tab[i].y;
                    r.out_heading = pose_tab[i].h;
                    r.out_time = pose_tab[i].t;
                    return r;
                end
            end
            if (pose_cnt >= nps_pkg::TABLE_DEPTH) begin
                r.status = nps_pkg::ST_FULL;
                return r;
            end
            pose_tab[pose_cnt] = p;
            r.status = nps_pkg::ST_INSERTED;
            r.entry_index = 6'(pose_cnt);
            r.out_x = p.x;
            r.out_y = p.y;
            r.out_heading = p.h;
            r.out_time = p.t;
            pose_cnt++;
            return r;
        end
        if (pose_cnt == 0) begin
            r.status = nps_pkg::ST_EMPTY;
            return r;
        end
        best = limit_sq;
        sel = 0;
        found = 0;
        for (int i = 0; i < pose_cnt; i++) begin
            d = sq_diff(p.x, pose_tab[i].x) + sq_diff(p.y, pose_tab[i].y)
                + 48'((64'(wgt) * 64'(sq_diff(p.h, pose_tab[i].h))) >> 8);
            if (d < best && d > {16'd0, excl_sq}) begin
                best = d;
                sel = i;
                found = 1;
            end
        end
        r.status = found ? nps_pkg::ST_SELECTED : nps_pkg::ST_FALLBACK;
        r.entry_index = 6'(sel);
        r.out_x = pose_tab[sel].x;
        r.out_y = pose_tab[sel].y;
        r.out_heading = pose_tab[sel].h;
        r.out_time = pose_tab[sel].t;
        r.best_distance_sq = best;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        nps_pkg::t_out_beat w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_data.status), 64'd0);
            end else begin
                w = expected_beats.pop_front();
                if (o_data.status !== w.status)
                    report_mismatch("status", 64'(o_data.status), 64'(w.status));
                if (o_data.entry_index !== w.entry_index)
                    report_mismatch("entry_index", 64'(o_data.entry_index),
                                    64'(w.entry_index));
                if (o_data.out_x !== w.out_x)
                    report_mismatch("out_x", 64'(o_data.out_x), 64'(w.out_x));
                if (o_data.out_y !== w.out_y)
                    report_mismatch("out_y", 64'(o_data.out_y), 64'(w.out_y));
                if (o_data.out_heading !== w.out_heading)
                    report_mismatch("out_heading", 64'(o_data.out_heading),
                                    64'(w.out_heading));
                if (o_data.out_time !== w.out_time)
                    report_mismatch("out_time", 64'(o_data.out_time), 64'(w.out_time));
                if (o_data.best_distance_sq !== w.best_distance_sq)
                    report_mismatch("best_distance_sq", 64'(o_data.best_distance_sq),
                                    64'(w.best_distance_sq));
            end
        end
    end

    // receiver stall pattern: while stall_on, i_ready drops at random, about one time in four
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b1;
        end else if (stall_on) begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_nearest_pose_selector_unit failed");
            $finish;
        end
    end

    task automatic send_beat(input nps_pkg::t_in_beat b);
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_beats = {expected_beats, select_pose(b)};
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_with_gap(input nps_pkg::t_in_beat b);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        send_beat(b);
    endtask

    task automatic drain;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (3 * nps_pkg::TABLE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            nps_pkg::CFG_ANGLE_WEIGHT: wgt = val[7:0];
            nps_pkg::CFG_EXCL_RADIUS:  excl_sq = val[31:0];
            nps_pkg::CFG_SEARCH_LIMIT: limit_sq = val;
            default: ;
        endcase
    endtask

    function automatic nps_pkg::t_in_beat make_beat(input logic op, input logic [19:0] x,
                                                    input logic [19:0] y,
                                                    input logic [15:0] h,
                                                    input logic [31:0] t);
        nps_pkg::t_in_beat b;
        b.opcode = op;
        b.pose_x = x;
        b.pose_y = y;
        b.pose_heading = h;
        b.pose_time = t;
        return b;
    endfunction

    function automatic nps_pkg::t_in_beat rand_beat(input bit near, input int qpct);
        logic [19:0] x, y;
        logic [15:0] h;
        x = 20'($urandom);
        y = 20'($urandom);
        h = 16'($urandom);
        if (near) begin
            x = 20'($signed(11'($urandom)));
            y = 20'($signed(11'($urandom)));
            h = 16'($signed(10'($urandom)));
        end
        return make_beat($urandom_range(0, 99) < qpct, x, y, h,
                         near ? {24'($urandom_range(0, 90)), 8'($urandom)} : $urandom);
    endfunction

    task automatic test_directed_edges;
        send_beat(make_beat(1'b1, 20'h0, 20'h0, 16'h0, 32'h0));
        send_beat(make_beat(1'b0, 20'h80000, 20'h7FFFF, 16'h8000, 32'h0));
        send_beat(make_beat(1'b0, 20'h7FFFF, 20'h80000, 16'h7FFF, 32'hFFFFFFFF));
        send_beat(make_beat(1'b0, 20'h1, 20'h2, 16'h3, 32'h000000FF));
        send_beat(make_beat(1'b0, 20'h0, 20'h0, 16'h0, 32'h00000100));
        send_beat(make_beat(1'b0, 20'h0, 20'h0, 16'h0, 32'hFFFFFF00));
        send_beat(make_beat(1'b1, 20'h7FFFF, 20'h80000, 16'h7FFF, 32'h0));
        send_beat(make_beat(1'b1, 20'h0, 20'h0, 16'h0, 32'h0));
        send_beat(make_beat(1'b1, 20'h80000, 20'h7FFFF, 16'h8000, 32'hFFFFFFFF));
        drain();
    endtask

    task automatic test_register_extremes;
        write_reg(nps_pkg::CFG_ANGLE_WEIGHT, 48'hFF);
        write_reg(nps_pkg::CFG_EXCL_RADIUS, 48'h0);
        write_reg(nps_pkg::CFG_SEARCH_LIMIT, 48'hFFFFFFFFFFFF);
        write_reg(CFG_NONE, 48'h123);
        send_beat(make_beat(1'b1, 20'h7FFFF, 20'h7FFFF, 16'h7FFF, 32'h0));
        send_beat(make_beat(1'b1, 20'h1, 20'h2, 16'h3, 32'h0));
        drain();
        write_reg(nps_pkg::CFG_EXCL_RADIUS, 48'hFFFFFFFF);
        write_reg(nps_pkg::CFG_ANGLE_WEIGHT, 48'h0);
        send_beat(make_beat(1'b1, 20'h0, 20'h0, 16'h0, 32'h0));
        drain();
        write_reg(nps_pkg::CFG_SEARCH_LIMIT, 48'h0);
        send_beat(make_beat(1'b1, 20'h1, 20'h0, 16'h0, 32'h0));
        drain();
        write_reg(nps_pkg::CFG_ANGLE_WEIGHT, 48'd100);
        write_reg(nps_pkg::CFG_EXCL_RADIUS, 48'd4194304);
        write_reg(nps_pkg::CFG_SEARCH_LIMIT, 48'd6553600000000);
    endtask

    task automatic test_fill_table;
        while (pose_cnt < nps_pkg::TABLE_DEPTH) begin
            send_with_gap(make_beat(1'b0, 20'($urandom), 20'($urandom), 16'($urandom),
                                    {24'(pose_cnt + 1000), 8'($urandom)}));
        end
        send_beat(make_beat(1'b0, 20'h5, 20'h5, 16'h5, 32'h0FFFFFFF));
        send_beat(make_beat(1'b0, 20'h5, 20'h5, 16'h5, {24'd1000, 8'h7}));
        send_beat(make_beat(1'b1, 20'h0, 20'h0, 16'h0, 32'h0));
        drain();
    endtask

    task automatic test_random_phase(input int count, input bit near, input int qpct);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end
            burst--;
            send_beat(rand_beat(near, qpct));
        end
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        err_cnt     = 0;
        idle_cycles = 0;
        stall_on    = 0;
        pose_cnt    = 0;
        wgt         = nps_pkg::RST_ANGLE_WEIGHT;
        excl_sq     = nps_pkg::RST_EXCL_RADIUS;
        limit_sq    = nps_pkg::RST_SEARCH_LIMIT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        stall_on = 1;
        test_register_extremes();
        test_random_phase(400, 1'b1, 60);
        write_reg(nps_pkg::CFG_ANGLE_WEIGHT, 48'($urandom_range(0, 255)));
        write_reg(nps_pkg::CFG_EXCL_RADIUS, 48'($urandom_range(0, 5000000)));
        write_reg(nps_pkg::CFG_SEARCH_LIMIT, 48'($urandom_range(1000000, 400000000)));
        stall_on = 0;
        test_random_phase(400, 1'b1, 70);
        stall_on = 1;
        test_fill_table();
        write_reg(nps_pkg::CFG_SEARCH_LIMIT, 48'hFFFFFFFFFFFF);
        write_reg(nps_pkg::CFG_EXCL_RADIUS, 48'($urandom));
        test_random_phase(700, 1'b0, 50);

        if (err_cnt == 0) begin
            $display("tb_nearest_pose_selector_unit passed");
        end else begin
            $display("tb_nearest_pose_selector_unit failed");
        end
        $finish;
    end
endmodule

### nearest_pose_selector_unit.f
hdl/nps_pkg.sv
hdl/nps_cell.sv
hdl/nearest_pose_selector_unit.sv
verif/tb_nearest_pose_selector_unit.sv
